### design/assert_macros.svh
// Assertion helpers for the file that checks this block.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CLNBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLNBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/clnbs_pkg.sv
package clnbs_pkg;

    localparam int WAIT_W = 13;
    localparam int IDX_W  = 5;

    // Request operations
    localparam logic [2:0] FUNC_CMD   = 3'd0;
    localparam logic [2:0] FUNC_DATA  = 3'd1;
    localparam logic [2:0] FUNC_POS   = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_INIT  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE  = 2'd0;
    localparam logic [1:0] CFG_SETTLE = 2'd1;
    localparam logic [1:0] CFG_CLEAR  = 2'd2;

    localparam logic [3:0]  PULSE_RST  = 4'd1;
    localparam logic [7:0]  SETTLE_RST = 8'd40;
    localparam logic [11:0] CLEAR_RST  = 12'd2000;

    // Controller command bytes
    localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY      = 8'h06;

    localparam logic [3:0] NIB_8BIT = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 13'd5000;
    localparam logic [WAIT_W-1:0] WAIT_MODE     = 13'd1000;

    // Phase index ranges of the power-up sequence and of a byte request
    localparam logic [IDX_W-1:0] INIT_FIRST_NIB  = 5'd1;
    localparam logic [IDX_W-1:0] INIT_FIRST_BYTE = 5'd9;
    localparam logic [IDX_W-1:0] INIT_LAST_IDX   = 5'd24;
    localparam logic [IDX_W-1:0] BYTE_LAST_IDX   = 5'd3;

    typedef struct packed {
        logic             capture;
        logic             emit;
        logic             init;
        logic             last_phase;
        logic [IDX_W-1:0] idx;
    } clnbs_cmd_t;

    typedef struct packed {
        logic slot_free;
    } clnbs_sts_t;

    function automatic logic [7:0] init_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISPLAY_ON;
            2'd2:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

endpackage

### design/clnbs_ctrl.sv
module clnbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          func,
    output logic                in_stall,
    input  clnbs_pkg::clnbs_sts_t sts,
    output clnbs_pkg::clnbs_cmd_t cmd
);
    import clnbs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             init_reg, init_next;
    logic             last_phase;

    assign in_stall   = (state_reg != ST_IDLE);
    assign last_phase = (idx_reg == (init_reg ? INIT_LAST_IDX : BYTE_LAST_IDX));

    always_comb
    begin
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.emit       = (state_reg == ST_RUN) && sts.slot_free;
        cmd.init       = init_reg;
        cmd.last_phase = last_phase;
        cmd.idx        = idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        init_next  = init_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // drop unused operation codes on accept
                if (in_valid && (func <= FUNC_INIT))
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                    init_next  = (func == FUNC_INIT);
                end
            end
            ST_RUN:
            begin
                if (sts.slot_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (last_phase)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            init_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            init_reg  <= init_next;
        end
    end

endmodule

### design/clnbs_dp.sv
module clnbs_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            func,
    input  logic [7:0]            value,
    input  logic                  row,
    input  logic [3:0]            column,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [11:0]           cfg_data,
    input  clnbs_pkg::clnbs_cmd_t cmd,
    output clnbs_pkg::clnbs_sts_t sts,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  reg_select,
    output logic                  enable,
    output logic [3:0]            nibble,
    output logic [12:0]           wait_us,
    output logic                  last
);
    import clnbs_pkg::*;

    logic [3:0]  pulse_reg;
    logic [7:0]  settle_reg;
    logic [11:0] clear_wait_reg;

    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic        clr_reg, clr_next;

    logic              out_valid_reg;
    logic              rs_out_reg, en_out_reg, last_out_reg;
    logic [3:0]        nib_out_reg;
    logic [WAIT_W-1:0] wait_out_reg;

    logic              ph_rs, ph_en;
    logic [3:0]        ph_nib;
    logic [WAIT_W-1:0] ph_extra, ph_wait;
    logic [IDX_W-1:0]  nib_ofs, byte_ofs;
    logic [7:0]        cur_byte;
    logic              cur_clr;
    logic [1:0]        k;

    assign sts.slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg      <= PULSE_RST;
            settle_reg     <= SETTLE_RST;
            clear_wait_reg <= CLEAR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PULSE:  pulse_reg      <= cfg_data[3:0];
                CFG_SETTLE: settle_reg     <= cfg_data[7:0];
                CFG_CLEAR:  clear_wait_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Reduce the request to one byte, its register select and its clear flag.
    always_comb
    begin
        byte_next = value;
        rs_next   = 1'b0;
        clr_next  = 1'b0;
        case (func)
            FUNC_CMD:   byte_next = value;
            FUNC_DATA:
            begin
                byte_next = value;
                rs_next   = 1'b1;
            end
            FUNC_POS:   byte_next = CMD_SET_ADDR | {1'b0, row, 2'b00, column};
            FUNC_CLEAR:
            begin
                byte_next = CMD_CLEAR;
                clr_next  = 1'b1;
            end
            default:    byte_next = value;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= byte_next;
            rs_reg   <= rs_next;
            clr_reg  <= clr_next;
        end
    end

    assign nib_ofs  = cmd.idx - INIT_FIRST_NIB;
    assign byte_ofs = cmd.idx - INIT_FIRST_BYTE;

    always_comb
    begin
        ph_rs    = 1'b0;
        ph_en    = 1'b0;
        ph_nib   = '0;
        ph_extra = '0;
        cur_byte = byte_reg;
        cur_clr  = clr_reg;
        k        = cmd.idx[1:0];
        if (cmd.init && (cmd.idx < INIT_FIRST_BYTE))
        begin
            // idle phase, then four single nibbles
            if (cmd.idx != '0)
            begin
                ph_en  = !nib_ofs[0];
                ph_nib = (nib_ofs[2:1] == 2'd3) ? NIB_4BIT : NIB_8BIT;
                if (nib_ofs[0])
                    ph_extra = {5'b0, settle_reg}
                             + ((nib_ofs[2:1] == 2'd0) ? WAIT_POWER_UP : WAIT_MODE);
            end
        end
        else
        begin
            if (cmd.init)
            begin
                cur_byte = init_byte(byte_ofs[3:2]);
                cur_clr  = (byte_ofs[3:2] == 2'd2);
                k        = byte_ofs[1:0];
            end
            else
                ph_rs = rs_reg;
            ph_en  = !k[0];
            ph_nib = k[1] ? cur_byte[3:0] : cur_byte[7:4];
            if (k == 2'd3)
                ph_extra = {5'b0, settle_reg} + (cur_clr ? {1'b0, clear_wait_reg} : '0);
        end
        if (!ph_en && cmd.init && (cmd.idx == '0))
            ph_wait = '0;
        else
            ph_wait = {9'b0, pulse_reg} + ph_extra;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rs_out_reg   <= ph_rs;
            en_out_reg   <= ph_en;
            nib_out_reg  <= ph_nib;
            wait_out_reg <= ph_wait;
            last_out_reg <= cmd.last_phase;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_out_reg;
    assign enable     = en_out_reg;
    assign nibble     = nib_out_reg;
    assign wait_us    = wait_out_reg;
    assign last       = last_out_reg;

endmodule

### design/char_lcd_nibble_bus_sequencer.sv
// Character LCD 4-bit bus sequencer.
// Input channel (in_valid/in_stall) takes one request beat: func selects
// command, data, set position, clear or power-up initialization; value, row
// and column are its operands. Unused func codes are taken and dropped.
// Output channel (out_valid/out_stall) gives one bus phase per beat:
// reg_select, enable, nibble, wait_us, and last on the final phase.
// A byte request gives 4 phases, initialization gives 25.
// After the request beat the controller enters its run state, and each phase
// is then registered into the output register. The phase counter in the
// controller advances one phase per cycle while the output slot is free;
// in_stall is high while phases remain to be issued.
// A stalled output beat holds in the output register and the counter waits.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 pulse_us, 1 settle_us, 2 clear_wait_us; write only while idle.
// Reset: registers return to 1, 40 and 2000 us; no phase is pending.
`include "assert_macros.svh"

module char_lcd_nibble_bus_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  value,
    input  logic        row,
    input  logic [3:0]  column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_select,
    output logic        enable,
    output logic [3:0]  nibble,
    output logic [12:0] wait_us,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import clnbs_pkg::*;

    clnbs_cmd_t cmd;
    clnbs_sts_t sts;

    assign cfg_ready = 1'b1;

    clnbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    clnbs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .value      (value),
        .row        (row),
        .column     (column),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .enable     (enable),
        .nibble     (nibble),
        .wait_us    (wait_us),
        .last       (last)
    );

    `CLNBS_ASSERT_IMPL(a_last_enable_low, out_valid && last, !enable, "last phase with enable high")
    `CLNBS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall && func <= FUNC_INIT, in_stall, "request not held off")
    `CLNBS_ASSERT_IMPL(a_emit_needs_slot, cmd.emit, sts.slot_free, "phase emitted into a full slot")

endmodule

### bench/tb_top.sv
module tb_top;
    import clnbs_pkg::*;

    // Controller codes and timings, kept apart from the design's package
    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [7:0] FUNC_SET_4B  = 8'h28;
    localparam logic [7:0] DISP_ON      = 8'h0C;
    localparam logic [7:0] CLEAR_CODE   = 8'h01;
    localparam logic [7:0] ENTRY_INC    = 8'h06;
    localparam logic [3:0] WAKE_NIB     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB = 4'h2;
    localparam int unsigned LONG_WAKE   = 5000;
    localparam int unsigned SHORT_WAKE  = 1000;
    localparam int LCD_ROWS = 2;
    localparam int LCD_COLS = 16;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [12:0] hold_us;
        logic        fin;
    } bus_phase_t;

    class lcd_phase_board;
        bus_phase_t  due[$];
        int unsigned bad;
        int unsigned pulse_us;
        int unsigned settle_us;
        int unsigned clear_us;

        function new();
            pulse_us  = 1;
            settle_us = 40;
            clear_us  = 2000;
            bad       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_PULSE:  pulse_us  = data[3:0];
                CFG_SETTLE: settle_us = data[7:0];
                CFG_CLEAR:  clear_us  = data;
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return due.size();
        endfunction

        function void add_phase(logic rs, logic en, logic [3:0] nib, int unsigned us);
            bus_phase_t p;
            p.rs      = rs;
            p.en      = en;
            p.nib     = nib;
            p.hold_us = 13'(us);
            p.fin     = 1'b0;
            due.push_back(p);
        endfunction

        function void add_nibble(logic rs, logic [3:0] nib, int unsigned extra);
            add_phase(rs, 1'b1, nib, pulse_us);
            add_phase(rs, 1'b0, nib, pulse_us + extra);
        endfunction

        function void add_octet(logic rs, logic [7:0] octet, int unsigned extra);
            add_nibble(rs, octet[7:4], 0);
            add_nibble(rs, octet[3:0], settle_us + extra);
        endfunction

        // Expand one accepted request into the bus phases it should produce.
        function void note_request(logic [2:0] f, logic [7:0] v, logic r, logic [3:0] c);
            int unsigned first;
            logic [6:0]  addr;
            first = due.size();
            case (f)
                FUNC_CMD:  add_octet(1'b0, v, 0);
                FUNC_DATA: add_octet(1'b1, v, 0);
                FUNC_POS:
                begin
                    addr = 7'((int'(r) % LCD_ROWS) * 64 + int'(c) % LCD_COLS);
                    add_octet(1'b0, SET_DDRAM | {1'b0, addr}, 0);
                end
                FUNC_CLEAR: add_octet(1'b0, CLEAR_CODE, clear_us);
                FUNC_INIT:
                begin
                    add_phase(1'b0, 1'b0, 4'h0, 0);
                    add_nibble(1'b0, WAKE_NIB, settle_us + LONG_WAKE);
                    add_nibble(1'b0, WAKE_NIB, settle_us + SHORT_WAKE);
                    add_nibble(1'b0, WAKE_NIB, settle_us + SHORT_WAKE);
                    add_nibble(1'b0, FOUR_BIT_NIB, settle_us + SHORT_WAKE);
                    add_octet(1'b0, FUNC_SET_4B, 0);
                    add_octet(1'b0, DISP_ON, 0);
                    add_octet(1'b0, CLEAR_CODE, clear_us);
                    add_octet(1'b0, ENTRY_INC, 0);
                end
                default: ;
            endcase
            if (due.size() > first)
                due[due.size() - 1].fin = 1'b1;
        endfunction

        function void check_phase(bus_phase_t got);
            bus_phase_t want;
            if (due.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display("unexpected phase: rs=%0d en=%0d nib=%h wait=%0d last=%0d",
                             got.rs, got.en, got.nib, got.hold_us, got.fin);
                return;
            end
            want = due.pop_front();
            if (want.rs !== got.rs || want.en !== got.en || want.nib !== got.nib ||
                want.hold_us !== got.hold_us || want.fin !== got.fin)
            begin
                bad++;
                if (bad <= 10)
                    $display("phase mismatch: exp rs=%0d en=%0d nib=%h wait=%0d last=%0d,",
                             want.rs, want.en, want.nib, want.hold_us, want.fin,
                             " got rs=%0d en=%0d nib=%h wait=%0d last=%0d",
                             got.rs, got.en, got.nib, got.hold_us, got.fin);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [7:0]  value;
    logic        row;
    logic [3:0]  column;
    logic        out_valid;
    logic        out_stall;
    logic        reg_select;
    logic        enable;
    logic [3:0]  nibble;
    logic [12:0] wait_us;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    bit calm = 1'b0;
    lcd_phase_board board = new();

    char_lcd_nibble_bus_sequencer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .value(value),
        .row(row),
        .column(column),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .reg_select(reg_select),
        .enable(enable),
        .nibble(nibble),
        .wait_us(wait_us),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic [2:0] f, input logic [7:0] v,
                                input logic r, input logic [3:0] c);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        func     = f;
        value    = v;
        row      = r;
        column   = c;
        do @(posedge clk); while (in_stall);
        board.note_request(f, v, r, c);
    endtask

    // Drop valid and hold until every expected phase is out, plus a margin.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [11:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_timing(input int unsigned p, input int unsigned s, input int unsigned cw);
        write_cfg(CFG_PULSE, 12'(p));
        write_cfg(CFG_SETTLE, 12'(s));
        write_cfg(CFG_CLEAR, 12'(cw));
    endtask

    // Send one random request; report whether it was a real operation.
    task automatic send_random(output bit counted);
        int unsigned pick;
        logic [2:0]  f;
        pick = $urandom_range(0, 99);
        if (pick < 30)      f = FUNC_CMD;
        else if (pick < 60) f = FUNC_DATA;
        else if (pick < 80) f = FUNC_POS;
        else if (pick < 88) f = FUNC_CLEAR;
        else if (pick < 94) f = FUNC_INIT;
        else                f = 3'(FUNC_INIT + $urandom_range(1, 3));
        counted = (f <= FUNC_INIT);
        send_request(f, 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    // Output side: draw a stall per beat, then take the next phase.
    initial
    begin
        int unsigned hold;
        bus_phase_t  got;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 15);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            got = {reg_select, enable, nibble, wait_us, last};
            board.check_phase(got);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned n;
        bit          counted;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_CMD;
        value     = 8'h00;
        row       = 1'b0;
        column    = 4'h0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PULSE;
        cfg_data  = 12'h000;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset timing first, then operand extremes and ignored codes
        send_request(FUNC_CMD,   8'h00, 1'b0, 4'h0);
        send_request(FUNC_CMD,   8'hFF, 1'b1, 4'hF);
        send_request(FUNC_DATA,  8'h00, 1'b1, 4'hF);
        send_request(FUNC_DATA,  8'hFF, 1'b0, 4'h0);
        send_request(FUNC_DATA,  8'hA5, 1'b1, 4'h5);
        send_request(FUNC_POS,   8'hFF, 1'b0, 4'h0);
        send_request(FUNC_POS,   8'h00, 1'b1, 4'hF);
        send_request(FUNC_POS,   8'h5A, 1'b1, 4'h0);
        send_request(FUNC_POS,   8'hC3, 1'b0, 4'hF);
        send_request(FUNC_CLEAR, 8'hFF, 1'b1, 4'hF);
        send_request(FUNC_INIT,  8'hFF, 1'b1, 4'hF);
        send_request(3'(FUNC_INIT + 1), 8'hFF, 1'b1, 4'hF);
        send_request(3'(FUNC_INIT + 2), 8'h00, 1'b0, 4'h0);
        send_request(3'(FUNC_INIT + 3), 8'h81, 1'b1, 4'h9);
        send_request(FUNC_DATA,  8'h5A, 1'b0, 4'hA);

        drain();
        set_timing(1, 1, 0);
        send_request(FUNC_CLEAR, 8'h00, 1'b0, 4'h0);
        send_request(FUNC_INIT,  8'h00, 1'b0, 4'h0);
        send_request(FUNC_DATA,  8'h3C, 1'b0, 4'h3);

        drain();
        set_timing(15, 255, 4095);
        send_request(FUNC_CLEAR, 8'h00, 1'b0, 4'h0);
        send_request(FUNC_INIT,  8'h00, 1'b0, 4'h0);
        send_request(FUNC_CMD,   8'h7E, 1'b1, 4'h7);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                1:       set_timing(1, 1, 0);
                3:       set_timing(15, 255, 4095);
                5:       set_timing(15, 1, 4095);
                default: set_timing($urandom_range(1, 15), $urandom_range(1, 255),
                                    $urandom_range(0, 4095));
            endcase
            n = 0;
            while (n < 63)
            begin
                if (n % 25 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 59) == 0)
                    drain();
                send_random(counted);
                if (counted)
                    n++;
            end
        end

        calm = 1'b0;
        @(negedge clk);
        in_valid = 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.bad == 0 && board.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/clnbs_pkg.sv
design/clnbs_ctrl.sv
design/clnbs_dp.sv
design/char_lcd_nibble_bus_sequencer.sv
bench/tb_top.sv
